@@ design/red_pkg.sv @@
// Shared types and constants for the run-list extent decoder.
package red_pkg;

  localparam int unsigned ByteOffsetBitsDef = 16;
  localparam int unsigned ByteOffsetW       = 16;
  localparam int unsigned ClusterW          = 63;
  localparam int unsigned CountW            = 64;
  localparam int unsigned RunCountW         = 16;
  localparam int unsigned MaxFieldBytes     = 8;
  localparam logic [7:0]  EndMarker         = 8'h00;
  localparam logic [RunCountW-1:0] MaxRunsRst = '1;

  typedef enum logic [1:0] {
    KindRun,
    KindEnd,
    KindErr
  } kind_e;

  typedef enum logic [2:0] {
    ErrClusterOvf,
    ErrNegative,
    ErrTooMany,
    ErrTotalOvf,
    ErrBadHeader,
    ErrTruncated
  } err_e;

  // run completion status, priority is resolved by the caller
  typedef struct packed {
    logic                cluster_ovf;
    logic                negative;
    logic                too_many;
    logic                total_ovf;
    logic [ClusterW-1:0] start;
    logic [CountW-1:0]   total;
  } fin_t;

endpackage

@@ design/red_finish.sv @@
// Run completion arithmetic: start cluster, cluster total and range checks.
module red_finish
  import red_pkg::*;
(
  input  logic [ClusterW-1:0]  last_cluster_i,
  input  logic [CountW-1:0]    offset_i,
  input  logic [3:0]           offset_width_i,
  input  logic [CountW-1:0]    length_i,
  input  logic [CountW-1:0]    total_i,
  input  logic [RunCountW-1:0] run_count_i,
  input  logic [RunCountW-1:0] max_runs_i,
  output fin_t                 fin_o
);

  logic              sparse;
  logic              sign;
  logic [CountW-1:0] delta;
  logic [CountW:0]   sum;
  logic [CountW:0]   tot;

  always_comb begin
    sparse = (offset_width_i == 4'd0);
    // top bit of the last offset byte; width 8 wraps to lane 7
    sign   = offset_i[{offset_width_i[2:0] - 3'd1, 3'b111}];
    for (int k = 0; k < MaxFieldBytes; k++) begin
      delta[k*8 +: 8] = (4'(k) < offset_width_i) ? offset_i[k*8 +: 8] : {8{sign}};
    end
    sum = {2'b00, last_cluster_i} + {delta[CountW-1], delta};
    tot = {1'b0, total_i} + {1'b0, length_i};

    fin_o.cluster_ovf = !sparse && !delta[CountW-1] && sum[CountW-1];
    fin_o.negative    = !sparse && delta[CountW-1] && sum[CountW];
    fin_o.too_many    = (run_count_i >= max_runs_i);
    fin_o.total_ovf   = tot[CountW];
    fin_o.start       = sparse ? '0 : sum[ClusterW-1:0];
    fin_o.total       = tot[CountW-1:0];
  end

endmodule

@@ design/runlist_extent_decoder.sv @@
// Top level of the byte-serial run-list extent decoder.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+----------------------------------
//  input   | in        | in_valid_i / in_ready_o    | data_byte, first_byte, last_byte
//  result  | out       | out_valid_o / out_ready_i  | kind, start, length, sparse,
//          |           |                            | total, error_code, byte_offset
//  config  | in        | cfg_we_i (no wait)         | max_runs
//
// One word per cycle: input register, one pass of decode logic, result register.
// The result register loads from the input register when the decode stage advances;
// the longest path is the 64-bit start cluster add in the completion unit.
// Reset clears all decode state and sets max_runs to 65535.
// A stalled result holds the decode stage; the input register still takes one word.
module runlist_extent_decoder
  import red_pkg::*;
#(
  parameter int unsigned BYTE_OFFSET_BITS = ByteOffsetBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RunCountW-1:0]   cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   first_byte_i,
  input  logic                   last_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             kind_o,
  output logic [ClusterW-1:0]    start_cluster_o,
  output logic [CountW-1:0]      length_clusters_o,
  output logic                   sparse_o,
  output logic [CountW-1:0]      total_clusters_o,
  output logic [2:0]             error_code_o,
  output logic [ByteOffsetW-1:0] byte_offset_o
);

  localparam int unsigned PosW = BYTE_OFFSET_BITS;

  typedef enum logic [1:0] {
    PhHeader,
    PhLength,
    PhOffset,
    PhIdle
  } phase_e;

  // input register
  logic       in_vld_q;
  logic [7:0] data_q;
  logic       first_q;
  logic       last_q;
  logic       go;
  logic       accept;

  // decode state
  phase_e               phase_q, phase_d, cur_phase;
  logic [3:0]           lw_q, lw_d, cur_lw;
  logic [3:0]           ow_q, ow_d, cur_ow;
  logic [3:0]           bt_q, bt_d, cur_bt, bt_inc;
  logic [CountW-1:0]    lacc_q, lacc_d, cur_lacc, lacc_new;
  logic [CountW-1:0]    oacc_q, oacc_d, cur_oacc, oacc_new;
  logic [ClusterW-1:0]  lastc_q, lastc_d, cur_lastc;
  logic [CountW-1:0]    total_q, total_d, cur_total;
  logic [RunCountW-1:0] rc_q, rc_d, cur_rc;
  logic [PosW-1:0]      pos_q, pos_d, cur_pos;
  logic [PosW-1:0]      rs_q, rs_d, cur_rs;
  logic [RunCountW-1:0] max_runs_q;

  // result register
  logic                   res_vld_q, res_vld_d;
  logic [1:0]             res_kind_q, res_kind_d;
  logic [ClusterW-1:0]    res_start_q, res_start_d;
  logic [CountW-1:0]      res_len_q, res_len_d;
  logic                   res_sparse_q, res_sparse_d;
  logic [CountW-1:0]      res_total_q, res_total_d;
  logic [2:0]             res_err_q, res_err_d;
  logic [ByteOffsetW-1:0] res_off_q, res_off_d;

  logic [CountW-1:0] fin_len;
  logic              lw_done;
  logic              ow_done;
  fin_t              fin;

  assign go         = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || go;
  assign accept     = in_valid_i && in_ready_o;

  // first_byte clears decode state ahead of the word itself
  always_comb begin
    cur_phase = first_q ? PhHeader : phase_q;
    cur_lw    = first_q ? '0 : lw_q;
    cur_ow    = first_q ? '0 : ow_q;
    cur_bt    = first_q ? '0 : bt_q;
    cur_lacc  = first_q ? '0 : lacc_q;
    cur_oacc  = first_q ? '0 : oacc_q;
    cur_lastc = first_q ? '0 : lastc_q;
    cur_total = first_q ? '0 : total_q;
    cur_rc    = first_q ? '0 : rc_q;
    cur_pos   = first_q ? '0 : pos_q;
    cur_rs    = first_q ? '0 : rs_q;
  end

  always_comb begin
    bt_inc   = cur_bt + 4'd1;
    lacc_new = cur_lacc;
    oacc_new = cur_oacc;
    lacc_new[{cur_bt[2:0], 3'b000} +: 8] = cur_lacc[{cur_bt[2:0], 3'b000} +: 8] | data_q;
    oacc_new[{cur_bt[2:0], 3'b000} +: 8] = cur_oacc[{cur_bt[2:0], 3'b000} +: 8] | data_q;
    lw_done  = (bt_inc >= cur_lw);
    ow_done  = (bt_inc >= cur_ow);
    fin_len  = (cur_phase == PhLength) ? lacc_new : cur_lacc;
  end

  red_finish u_finish (
    .last_cluster_i (cur_lastc),
    .offset_i       (oacc_new),
    .offset_width_i (cur_ow),
    .length_i       (fin_len),
    .total_i        (cur_total),
    .run_count_i    (cur_rc),
    .max_runs_i     (max_runs_q),
    .fin_o          (fin)
  );

  always_comb begin
    logic finish;
    logic emit;
    logic trunc;

    phase_d = cur_phase;
    lw_d    = cur_lw;
    ow_d    = cur_ow;
    bt_d    = cur_bt;
    lacc_d  = cur_lacc;
    oacc_d  = cur_oacc;
    lastc_d = cur_lastc;
    total_d = cur_total;
    rc_d    = cur_rc;
    pos_d   = cur_pos;
    rs_d    = cur_rs;
    finish  = 1'b0;
    emit    = 1'b0;
    trunc   = 1'b0;

    res_kind_d   = KindRun;
    res_start_d  = '0;
    res_len_d    = '0;
    res_sparse_d = 1'b0;
    res_total_d  = '0;
    res_err_d    = ErrClusterOvf;
    res_off_d    = ByteOffsetW'(cur_rs);

    if (cur_phase != PhIdle) begin
      pos_d = cur_pos + PosW'(1);
      case (cur_phase)
        PhHeader: begin
          if (data_q == EndMarker) begin
            emit        = 1'b1;
            res_kind_d  = KindEnd;
            res_total_d = cur_total;
            res_off_d   = ByteOffsetW'(cur_pos);
            phase_d     = PhIdle;
          end else begin
            lw_d = data_q[3:0];
            ow_d = data_q[7:4];
            if (data_q[3:0] == 4'd0 || data_q[3:0] > 4'd8 || data_q[7:4] > 4'd8) begin
              emit       = 1'b1;
              res_kind_d = KindErr;
              res_err_d  = ErrBadHeader;
              res_off_d  = ByteOffsetW'(cur_pos);
              phase_d    = PhIdle;
            end else begin
              rs_d    = cur_pos;
              bt_d    = '0;
              lacc_d  = '0;
              oacc_d  = '0;
              phase_d = PhLength;
              trunc   = last_q;
              res_off_d = ByteOffsetW'(cur_pos);
            end
          end
        end
        PhLength: begin
          lacc_d = lacc_new;
          bt_d   = bt_inc;
          if (lw_done && cur_ow == 4'd0) begin
            finish = 1'b1;
          end else begin
            if (lw_done) begin
              bt_d    = '0;
              phase_d = PhOffset;
            end
            trunc = last_q;
          end
        end
        PhOffset: begin
          oacc_d = oacc_new;
          bt_d   = bt_inc;
          if (ow_done) begin
            finish = 1'b1;
          end else begin
            trunc = last_q;
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase

      if (trunc) begin
        emit       = 1'b1;
        res_kind_d = KindErr;
        res_err_d  = ErrTruncated;
        phase_d    = PhIdle;
      end

      if (finish) begin
        emit       = 1'b1;
        res_kind_d = KindErr;
        res_off_d  = ByteOffsetW'(cur_rs);
        phase_d    = PhIdle;
        if (fin.cluster_ovf) begin
          res_err_d = ErrClusterOvf;
        end else if (fin.negative) begin
          res_err_d = ErrNegative;
        end else if (fin.too_many) begin
          res_err_d = ErrTooMany;
        end else if (fin.total_ovf) begin
          res_err_d = ErrTotalOvf;
        end else begin
          total_d = fin.total;
          rc_d    = cur_rc + RunCountW'(1);
          if (cur_ow != 4'd0) begin
            lastc_d = fin.start;
          end
          if (last_q) begin
            // complete run but no room left for the end marker
            res_err_d = ErrTruncated;
            res_off_d = ByteOffsetW'(pos_d);
          end else begin
            phase_d      = PhHeader;
            res_kind_d   = KindRun;
            res_start_d  = fin.start;
            res_len_d    = fin_len;
            res_sparse_d = (cur_ow == 4'd0);
            res_total_d  = fin.total;
          end
        end
      end
    end

    res_vld_d = emit;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q  <= data_byte_i;
      first_q <= first_byte_i;
      last_q  <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      max_runs_q   <= MaxRunsRst;
      phase_q      <= PhHeader;
      lw_q         <= '0;
      ow_q         <= '0;
      bt_q         <= '0;
      lacc_q       <= '0;
      oacc_q       <= '0;
      lastc_q      <= '0;
      total_q      <= '0;
      rc_q         <= '0;
      pos_q        <= '0;
      rs_q         <= '0;
      res_vld_q    <= 1'b0;
      res_kind_q   <= '0;
      res_start_q  <= '0;
      res_len_q    <= '0;
      res_sparse_q <= 1'b0;
      res_total_q  <= '0;
      res_err_q    <= '0;
      res_off_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_runs_q <= cfg_wdata_i;
      end
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (go) begin
        in_vld_q <= 1'b0;
      end
      if (go) begin
        phase_q      <= phase_d;
        lw_q         <= lw_d;
        ow_q         <= ow_d;
        bt_q         <= bt_d;
        lacc_q       <= lacc_d;
        oacc_q       <= oacc_d;
        lastc_q      <= lastc_d;
        total_q      <= total_d;
        rc_q         <= rc_d;
        pos_q        <= pos_d;
        rs_q         <= rs_d;
        res_vld_q    <= res_vld_d;
        res_kind_q   <= res_kind_d;
        res_start_q  <= res_start_d;
        res_len_q    <= res_len_d;
        res_sparse_q <= res_sparse_d;
        res_total_q  <= res_total_d;
        res_err_q    <= res_err_d;
        res_off_q    <= res_off_d;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = res_vld_q;
  assign kind_o            = res_kind_q;
  assign start_cluster_o   = res_start_q;
  assign length_clusters_o = res_len_q;
  assign sparse_o          = res_sparse_q;
  assign total_clusters_o  = res_total_q;
  assign error_code_o      = res_err_q;
  assign byte_offset_o     = res_off_q;

endmodule

@@ tb/tb_runlist_extent_decoder.sv @@
// Self-checking testbench for the run-list extent decoder: directed table, then random lists.
`timescale 1ns / 100ps

module tb_runlist_extent_decoder
  import red_pkg::*;
();

  localparam int unsigned SinkHold    = 400;    // one long receiver hold-off
  localparam int unsigned HoldAt      = 300;    // words fed before that hold starts
  localparam int unsigned QuietLimit  = 3000;   // cycles with no handshake before giving up
  localparam int unsigned PhaseWords  = 120;
  localparam int unsigned LongWords   = 160;    // one list made of many short runs
  localparam int unsigned SettleWait  = 6;
  localparam int unsigned DrainCycles = 10;

  typedef enum logic [1:0] {WalkHeader, WalkLength, WalkOffset, WalkIdle} walk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first_b;
    logic       last_b;
  } in_word_t;

  typedef struct packed {
    kind_e                  kind;
    logic [ClusterW-1:0]    first_cl;
    logic [CountW-1:0]      run_len;
    logic                   is_sparse;
    logic [CountW-1:0]      total;
    err_e                   code;
    logic [ByteOffsetW-1:0] offs;
  } extent_t;

  typedef struct packed {
    in_word_t w;
    logic     typed;
    extent_t  want;
  } dir_row_t;

  localparam extent_t NoWord = '0;

  // Typed rows carry a result readable by eye; for the rest the result comes from walk_byte.
  localparam dir_row_t DirRows [28] = '{
    '{'{8'h00, 1'b1, 1'b0}, 1'b1,
      '{KindEnd, 63'd0, 64'd0, 1'b0, 64'd0, ErrClusterOvf, 16'd0}},
    '{'{8'h11, 1'b1, 1'b0}, 1'b0, NoWord},
    '{'{8'h05, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'h10, 1'b0, 1'b0}, 1'b1,
      '{KindRun, 63'd16, 64'd5, 1'b0, 64'd5, ErrClusterOvf, 16'd0}},
    '{'{8'h01, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b1,
      '{KindRun, 63'd0, 64'd255, 1'b1, 64'd260, ErrClusterOvf, 16'd3}},
    '{'{8'h11, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'h01, 1'b0, 1'b0}, 1'b0, NoWord},
    // delta of -17 from cluster 16
    '{'{8'hEF, 1'b0, 1'b0}, 1'b1,
      '{KindErr, 63'd0, 64'd0, 1'b0, 64'd0, ErrNegative, 16'd5}},
    // decoder idle: ignored
    '{'{8'h22, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'h90, 1'b1, 1'b0}, 1'b1,
      '{KindErr, 63'd0, 64'd0, 1'b0, 64'd0, ErrBadHeader, 16'd0}},
    '{'{8'h21, 1'b1, 1'b0}, 1'b0, NoWord},
    '{'{8'h01, 1'b0, 1'b1}, 1'b1,
      '{KindErr, 63'd0, 64'd0, 1'b0, 64'd0, ErrTruncated, 16'd0}},
    // run completes on the last byte: truncation reported where the next header goes
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, NoWord},
    '{'{8'h07, 1'b0, 1'b1}, 1'b1,
      '{KindErr, 63'd0, 64'd0, 1'b0, 64'd0, ErrTruncated, 16'd2}},
    '{'{8'h81, 1'b1, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'h7F, 1'b0, 1'b0}, 1'b1,
      '{KindRun, 63'h7FFF_FFFF_FFFF_FFFF, 64'd255, 1'b0, 64'd255, ErrClusterOvf, 16'd0}},
    '{'{8'h11, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, NoWord},
    '{'{8'h01, 1'b0, 1'b0}, 1'b1,
      '{KindErr, 63'd0, 64'd0, 1'b0, 64'd0, ErrClusterOvf, 16'd10}}
  };

  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   cfg_we_i          = 1'b0;
  logic [RunCountW-1:0]   cfg_wdata_i       = '0;
  logic                   in_valid_i        = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i       = '0;
  logic                   first_byte_i      = 1'b0;
  logic                   last_byte_i       = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i       = 1'b0;
  logic [1:0]             kind_o;
  logic [ClusterW-1:0]    start_cluster_o;
  logic [CountW-1:0]      length_clusters_o;
  logic                   sparse_o;
  logic [CountW-1:0]      total_clusters_o;
  logic [2:0]             error_code_o;
  logic [ByteOffsetW-1:0] byte_offset_o;

  // decoder mirror
  walk_e                        cur_phase;
  logic [3:0]                   len_w, off_w, taken;
  logic [CountW-1:0]            len_acc, off_acc, cl_total;
  logic [ClusterW-1:0]          cursor;
  logic [RunCountW-1:0]         runs_done, max_runs_reg;
  logic [ByteOffsetBitsDef-1:0] byte_pos, hdr_pos;

  extent_t     extents_due [$];
  int          fail_count = 0;
  int unsigned words_fed  = 0;
  int unsigned feed_calm  = 0;
  int unsigned sink_calm  = 0;
  bit          hold_req   = 1'b0;

  runlist_extent_decoder i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Mostly back to back, some short gaps, a few long ones, and now and then a calm stretch.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_walk();
    cur_phase = WalkHeader;
    len_w     = '0;
    off_w     = '0;
    taken     = '0;
    len_acc   = '0;
    off_acc   = '0;
    cursor    = '0;
    cl_total  = '0;
    runs_done = '0;
    byte_pos  = '0;
    hdr_pos   = '0;
  endfunction

  function automatic extent_t make_word(kind_e k, logic [ClusterW-1:0] s, logic [CountW-1:0] l,
                                        logic sp, logic [CountW-1:0] t, err_e e,
                                        logic [ByteOffsetW-1:0] o);
    extent_t x;
    x.kind      = k;
    x.first_cl  = s;
    x.run_len   = l;
    x.is_sparse = sp;
    x.total     = t;
    x.code      = e;
    x.offs      = o;
    return x;
  endfunction

  function automatic extent_t fail_word(err_e e, logic [ByteOffsetW-1:0] o);
    cur_phase = WalkIdle;
    return make_word(KindErr, '0, '0, 1'b0, '0, e, o);
  endfunction

  function automatic extent_t close_run(logic last_b);
    logic [CountW-1:0]   delta, mag, sum;
    logic [ClusterW-1:0] start_cl;
    int unsigned         nbits;
    logic                sp;
    start_cl = '0;
    sp = (off_w == 0);
    if (!sp) begin
      delta = off_acc;
      nbits = 8 * off_w;
      if (nbits < CountW && delta[nbits-1]) delta = delta | ~((64'd1 << nbits) - 64'd1);
      if (!delta[CountW-1]) begin
        // both operands below 2^63, so bit 63 of the sum flags the overflow
        sum = {1'b0, cursor} + delta;
        if (sum[CountW-1]) return fail_word(ErrClusterOvf, hdr_pos);
        start_cl = sum[ClusterW-1:0];
      end else begin
        mag = ~delta + 64'd1;
        if (mag > {1'b0, cursor}) return fail_word(ErrNegative, hdr_pos);
        start_cl = cursor - mag[ClusterW-1:0];
      end
    end
    if (runs_done >= max_runs_reg) return fail_word(ErrTooMany, hdr_pos);
    if (len_acc > ~cl_total) return fail_word(ErrTotalOvf, hdr_pos);
    cl_total  = cl_total + len_acc;
    runs_done = runs_done + 1'b1;
    if (!sp) cursor = start_cl;
    cur_phase = WalkHeader;
    if (last_b) return fail_word(ErrTruncated, byte_pos);
    return make_word(KindRun, start_cl, len_acc, sp, cl_total, ErrClusterOvf, hdr_pos);
  endfunction

  // Advance the mirror by one input word; returns 1 when the word yields a result.
  function automatic bit walk_byte(input in_word_t w, output extent_t res);
    logic [ByteOffsetBitsDef-1:0] here;
    res = '0;
    if (w.first_b) clear_walk();
    if (cur_phase == WalkIdle) return 0;
    here     = byte_pos;
    byte_pos = byte_pos + 1'b1;
    case (cur_phase)
      WalkHeader: begin
        if (w.data == EndMarker) begin
          cur_phase = WalkIdle;
          res = make_word(KindEnd, '0, '0, 1'b0, cl_total, ErrClusterOvf, here);
          return 1;
        end
        len_w = w.data[3:0];
        off_w = w.data[7:4];
        if (len_w == 0 || len_w > MaxFieldBytes || off_w > MaxFieldBytes) begin
          res = fail_word(ErrBadHeader, here);
          return 1;
        end
        hdr_pos   = here;
        taken     = '0;
        len_acc   = '0;
        off_acc   = '0;
        cur_phase = WalkLength;
      end
      WalkLength: begin
        len_acc = len_acc | (64'(w.data) << (8 * taken[2:0]));
        taken   = taken + 4'd1;
        if (taken >= len_w) begin
          if (off_w == 0) begin
            res = close_run(w.last_b);
            return 1;
          end
          taken     = '0;
          cur_phase = WalkOffset;
        end
      end
      default: begin
        off_acc = off_acc | (64'(w.data) << (8 * taken[2:0]));
        taken   = taken + 4'd1;
        if (taken >= off_w) begin
          res = close_run(w.last_b);
          return 1;
        end
      end
    endcase
    if (w.last_b) begin
      res = fail_word(ErrTruncated, hdr_pos);
      return 1;
    end
    return 0;
  endfunction

  task automatic feed_word(input in_word_t w, input logic typed, input extent_t want);
    int unsigned gap;
    extent_t     res;
    gap = draw_gap(feed_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= w.data;
    first_byte_i <= w.first_b;
    last_byte_i  <= w.last_b;
    do @(posedge clk_i); while (!in_ready_o);
    if (walk_byte(w, res) && !typed) extents_due = {extents_due, res};
    if (typed) extents_due = {extents_due, want};
    words_fed++;
    if (words_fed == HoldAt) hold_req <= 1'b1;
  endtask

  task automatic set_max_runs(input logic [RunCountW-1:0] v);
    in_valid_i <= 1'b0;
    while (extents_due.size() != 0) @(posedge clk_i);
    // a word that yields no result may still be in flight
    repeat (SettleWait) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    max_runs_reg = v;
  endtask

  task automatic random_list();
    in_word_t    seq [$];
    int unsigned nruns, lw, ow, r;
    logic [7:0]  hdr, v;
    bit          far;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 6))
        seq = {seq, in_word_t'{8'($urandom), 1'($urandom), 1'($urandom_range(0, 3) == 0)}};
    end else begin
      nruns = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
      repeat (nruns) begin
        r  = $urandom_range(0, 99);
        lw = (r < 10) ? MaxFieldBytes : $urandom_range(1, 3);
        r  = $urandom_range(0, 99);
        ow = (r < 25) ? 0 : (r < 35) ? MaxFieldBytes : $urandom_range(1, 3);
        if ($urandom_range(0, 29) == 0) begin
          do hdr = 8'($urandom);
          while (hdr == EndMarker || (hdr[3:0] != 0 && hdr[3:0] <= MaxFieldBytes &&
                                      hdr[7:4] <= MaxFieldBytes));
          seq = {seq, in_word_t'{hdr, 1'b0, 1'b0}};
        end else begin
          seq = {seq, in_word_t'{8'({ow[3:0], lw[3:0]}), 1'b0, 1'b0}};
          r = $urandom_range(0, 99);
          for (int j = 0; j < lw; j++) begin
            v = (r < 40 && lw == MaxFieldBytes) ? 8'hFF : 8'($urandom);
            seq = {seq, in_word_t'{v, 1'b0, 1'b0}};
          end
          far = ($urandom_range(0, 99) < 30);
          for (int j = 0; j < ow; j++) begin
            v = 8'($urandom);
            // full-width jump to the top cluster, otherwise mostly forward deltas
            if (ow == MaxFieldBytes && far) v = (j == ow - 1) ? 8'h7F : 8'hFF;
            else if (j == ow - 1 && $urandom_range(0, 3) != 0) v[7] = 1'b0;
            seq = {seq, in_word_t'{v, 1'b0, 1'b0}};
          end
        end
      end
      r = $urandom_range(0, 99);
      if (r < 75) seq = {seq, in_word_t'{EndMarker, 1'b0, 1'($urandom_range(0, 4) == 0)}};
      else if (r < 90 && seq.size() != 0) seq[$urandom_range(0, seq.size() - 1)].last_b = 1'b1;
      if (seq.size() == 0) seq = {seq, in_word_t'{EndMarker, 1'b0, 1'b0}};
      seq[0].first_b = 1'b1;
    end
    foreach (seq[i]) feed_word(seq[i], 1'b0, NoWord);
  endtask

  // Many short runs back to back inside one list.
  task automatic long_list();
    int unsigned n;
    n = 0;
    while (n < LongWords) begin
      if ($urandom_range(0, 1) != 0) begin
        feed_word(in_word_t'{8'h11, 1'(n == 0), 1'b0}, 1'b0, NoWord);
        feed_word(in_word_t'{8'($urandom), 1'b0, 1'b0}, 1'b0, NoWord);
        feed_word(in_word_t'{8'($urandom_range(0, 127)), 1'b0, 1'b0}, 1'b0, NoWord);
        n += 3;
      end else begin
        feed_word(in_word_t'{8'h01, 1'(n == 0), 1'b0}, 1'b0, NoWord);
        feed_word(in_word_t'{8'($urandom), 1'b0, 1'b0}, 1'b0, NoWord);
        n += 2;
      end
    end
    feed_word(in_word_t'{EndMarker, 1'b0, 1'b0}, 1'b0, NoWord);
  endtask

  task automatic take_result();
    extent_t want;
    if (extents_due.size() == 0) begin
      $error("result word with nothing expected: kind %0d offset %0d", kind_o, byte_offset_o);
      fail_count++;
      return;
    end
    want = extents_due.pop_front();
    if (kind_o !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, kind_o);
      fail_count++;
    end
    if (start_cluster_o !== want.first_cl) begin
      $error("start_cluster: expected %0h, actual %0h", want.first_cl, start_cluster_o);
      fail_count++;
    end
    if (length_clusters_o !== want.run_len) begin
      $error("length_clusters: expected %0h, actual %0h", want.run_len, length_clusters_o);
      fail_count++;
    end
    if (sparse_o !== want.is_sparse) begin
      $error("sparse: expected %0d, actual %0d", want.is_sparse, sparse_o);
      fail_count++;
    end
    if (total_clusters_o !== want.total) begin
      $error("total_clusters: expected %0h, actual %0h", want.total, total_clusters_o);
      fail_count++;
    end
    if (error_code_o !== want.code) begin
      $error("error_code: expected %0d, actual %0d", want.code, error_code_o);
      fail_count++;
    end
    if (byte_offset_o !== want.offs) begin
      $error("byte_offset: expected %0d, actual %0d", want.offs, byte_offset_o);
      fail_count++;
    end
  endtask

  // result side
  initial begin
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) take_result();
      // long hold-off while words keep coming, so the input side backs up
      if (hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = SinkHold;
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        stall_left = draw_gap(sink_calm);
        out_ready_i <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("runlist_extent_decoder: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [RunCountW-1:0] limits [7];
    int unsigned          phase_base;
    bit                   long_done;
    clear_walk();
    max_runs_reg = MaxRunsRst;
    long_done    = 1'b0;
    limits = '{16'd1, 16'd2, MaxRunsRst, 16'($urandom_range(4, 40)), 16'd3,
               16'($urandom_range(1, 65535)), 16'd1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DirRows); i++)
      feed_word(DirRows[i].w, DirRows[i].typed, DirRows[i].want);

    foreach (limits[p]) begin
      set_max_runs(limits[p]);
      if (limits[p] == MaxRunsRst && !long_done) begin
        long_done = 1'b1;
        long_list();
      end
      phase_base = words_fed;
      while (words_fed - phase_base < PhaseWords) random_list();
    end

    in_valid_i <= 1'b0;
    while (extents_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("runlist_extent_decoder: match");
    end else begin
      $display("runlist_extent_decoder: mismatch");
    end
    $finish;
  end

endmodule
